// ===== rtl/core/capacitive_touch_detector_top_macros.svh =====
// assertion macros for the capacitive touch detector checker
// no dependencies; included by the checker file
`ifndef CAPACITIVE_TOUCH_DETECTOR_TOP_MACROS_SVH
`define CAPACITIVE_TOUCH_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ctd_pkg.sv =====
// shared constants for the capacitive touch detector
// no dependencies; imported by the top level and the checker
package ctd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int GIDX_W           = 8;
    localparam int EVENT_W          = 2;
    localparam int FLAG_BITS        = 4 + EVENT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_WINDOW_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_WINDOW_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_GROUP = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0]  GATE_THRESHOLD_RST    = 16'd50;
    localparam logic [CFG_W-1:0]  IDLE_WINDOW_LOW_RST   = 16'd60;
    localparam logic [CFG_W-1:0]  IDLE_WINDOW_HIGH_RST  = 16'd80;
    localparam logic [GIDX_W-1:0] SAMPLES_PER_GROUP_RST = 8'd3;

    // change event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd2;

    // result bit positions in the master tdata
    localparam int BIT_CALIBRATED = 0;
    localparam int BIT_REJECTED   = 1;
    localparam int BIT_DECIDED    = 2;
    localparam int BIT_TOUCHED    = 3;
    localparam int BIT_EVENT_LO   = 4;

endpackage

// ===== rtl/core/capacitive_touch_detector_top.sv =====
// capacitive touch detector: calibration, group peak and touch decision
// depends on ctd_pkg
//
// usage
//   slave stream carries one charge time per transfer (tdata, low bits)
//   master stream returns exactly one result per accepted sample
//   config port: write enable, register index, data; writes take effect at
//   once; the user must make them only while idle; the block does not check
// datapath and throughput
//   a sample goes into an input register on its transfer, is judged when
//   the output register has room and then lands in the output register;
//   one sample per cycle sustained while the master side does not stall,
//   set by the combinational compare/max path
// reset
//   synchronous, active low; config returns to its defaults, the block
//   forgets its baseline and recalibrates, no result is pending
// stall
//   while the master side stalls, the output register holds its result and
//   one more sample can wait in the input register; tready drops only when
//   both are full
module capacitive_touch_detector_top
    import ctd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata: charge_time, zero pad
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // master stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata: calibrated, calibration_rejected, decision_made, touched,
    //        change_event[1:0], group_peak, zero pad
    output logic [((SAMPLE_WIDTH+FLAG_BITS+7)/8)*8-1:0] m_axis_tdata,
    // config write port
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]         i_cfg_wdata
);

    localparam int OUT_W = ((SAMPLE_WIDTH + FLAG_BITS + 7) / 8) * 8;
    // one bit above the wider of sample and config, so baseline + gate fits
    localparam int CMP_W = ((SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W) + 1;

    // config registers
    logic [CFG_W-1:0]        r_gate;
    logic [CFG_W-1:0]        r_win_lo;
    logic [CFG_W-1:0]        r_win_hi;
    logic [GIDX_W-1:0]       r_spg;

    // input register
    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_in_sample;

    // detector state
    logic                    r_cal,      n_cal;
    logic [SAMPLE_WIDTH-1:0] r_base,     n_base;
    logic [GIDX_W-1:0]       r_gidx,     n_gidx;
    logic [SAMPLE_WIDTH-1:0] r_peak,     n_peak;
    logic                    r_confirm,  n_confirm;
    logic                    r_touched,  n_touched;

    // output register
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data, n_out_data;

    logic                    s_xfer;
    logic                    advance;
    logic                    fire;

    // result fields for the sample being judged
    logic                    rejected;
    logic                    decided;
    logic [EVENT_W-1:0]      event_code;
    logic [SAMPLE_WIDTH-1:0] peak_out;

    // datapath helpers
    logic [CMP_W-1:0]        x_ext;
    logic [CMP_W-1:0]        limit;
    logic [SAMPLE_WIDTH-1:0] peak_new;
    logic [GIDX_W-1:0]       gidx_inc;
    logic [GIDX_W-1:0]       grp_size;
    logic                    above;
    logic                    now_touched;

    // output register frees up when empty or being taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate   <= GATE_THRESHOLD_RST;
            r_win_lo <= IDLE_WINDOW_LOW_RST;
            r_win_hi <= IDLE_WINDOW_HIGH_RST;
            r_spg    <= SAMPLES_PER_GROUP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_GATE_THRESHOLD:    r_gate   <= i_cfg_wdata;
                REG_IDLE_WINDOW_LOW:   r_win_lo <= i_cfg_wdata;
                REG_IDLE_WINDOW_HIGH:  r_win_hi <= i_cfg_wdata;
                REG_SAMPLES_PER_GROUP: r_spg    <= i_cfg_wdata[GIDX_W-1:0];
            endcase
        end
    end

    // input register: holds one sample until the output side has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_sample <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    // judge one sample: calibration, running peak, group decision
    always_comb begin
        n_cal       = r_cal;
        n_base      = r_base;
        n_gidx      = r_gidx;
        n_peak      = r_peak;
        n_confirm   = r_confirm;
        n_touched   = r_touched;
        rejected    = 1'b0;
        decided     = 1'b0;
        event_code  = EV_NONE;
        peak_out    = '0;
        now_touched = r_touched;

        x_ext    = CMP_W'(r_in_sample);
        limit    = CMP_W'(r_base) + CMP_W'(r_gate);
        peak_new = (r_in_sample > r_peak) ? r_in_sample : r_peak;
        gidx_inc = r_gidx + GIDX_W'(1);
        // a group size of zero acts as one
        grp_size = (r_spg == '0) ? GIDX_W'(1) : r_spg;
        above    = CMP_W'(peak_new) > limit;

        if (!r_cal) begin
            // baseline must sit strictly inside the idle window
            if ((CMP_W'(r_win_lo) < x_ext) && (x_ext < CMP_W'(r_win_hi))) begin
                n_base = r_in_sample;
                n_cal  = 1'b1;
            end else begin
                rejected = 1'b1;
            end
        end else if (gidx_inc >= grp_size) begin
            // group ends (also when the size was lowered mid group)
            peak_out = peak_new;
            n_gidx   = '0;
            n_peak   = '0;
            if (r_confirm) begin
                n_confirm   = 1'b0;
                decided     = 1'b1;
                now_touched = above;
            end else if (above) begin
                n_confirm = 1'b1;
            end else begin
                decided     = 1'b1;
                now_touched = 1'b0;
            end
            if (decided && (now_touched != r_touched)) begin
                event_code = now_touched ? EV_PRESS : EV_RELEASE;
                n_touched  = now_touched;
            end
        end else begin
            n_gidx = gidx_inc;
            n_peak = peak_new;
        end

        n_out_data = '0;
        n_out_data[BIT_CALIBRATED] = n_cal;
        n_out_data[BIT_REJECTED]   = rejected;
        n_out_data[BIT_DECIDED]    = decided;
        n_out_data[BIT_TOUCHED]    = n_touched;
        n_out_data[BIT_EVENT_LO +: EVENT_W]      = event_code;
        n_out_data[FLAG_BITS +: SAMPLE_WIDTH]    = peak_out;
    end

    // detector state advances once per judged sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal     <= 1'b0;
            r_base    <= '0;
            r_gidx    <= '0;
            r_peak    <= '0;
            r_confirm <= 1'b0;
            r_touched <= 1'b0;
        end else if (fire) begin
            r_cal     <= n_cal;
            r_base    <= n_base;
            r_gidx    <= n_gidx;
            r_peak    <= n_peak;
            r_confirm <= n_confirm;
            r_touched <= n_touched;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== rtl/core/ctd_checker.sv =====
// port-level checker for the capacitive touch detector, with its bind
// depends on ctd_pkg and capacitive_touch_detector_top_macros.svh
`include "capacitive_touch_detector_top_macros.svh"

module ctd_checker
    import ctd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [((SAMPLE_WIDTH+FLAG_BITS+7)/8)*8-1:0] m_axis_tdata
);

    logic [EVENT_W-1:0] ev;

    assign ev = m_axis_tdata[BIT_EVENT_LO +: EVENT_W];

    // stalled result holds
    `CTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a rejected calibration sample leaves the block uncalibrated
    `CTD_ASSERT_NOW(a_reject_uncal, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[BIT_REJECTED],
        !m_axis_tdata[BIT_CALIBRATED], "rejected sample while calibrated")

    // events only come with a decision and agree with the touched state
    `CTD_ASSERT_NOW(a_event_decided, i_clk, i_rst_n,
        m_axis_tvalid && (ev != EV_NONE),
        m_axis_tdata[BIT_DECIDED] && m_axis_tdata[BIT_CALIBRATED],
        "event without decision")

    `CTD_ASSERT_NOW(a_event_state, i_clk, i_rst_n, m_axis_tvalid,
        ((ev == EV_NONE) || ((ev == EV_PRESS) && m_axis_tdata[BIT_TOUCHED])
         || ((ev == EV_RELEASE) && !m_axis_tdata[BIT_TOUCHED])),
        "bad event code or event against touched state")

endmodule

bind capacitive_touch_detector_top ctd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ctd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
